### rtl/assert_macros.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on clk and held off during reset.
`define RT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen.
`define RT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/rofr_pkg.sv
// Shared types and codes for the rectangle rasterizer.
`default_nettype none

package rofr_pkg;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_DRAW  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [7:0] KIND_OUTLINE = 8'h72;
	localparam logic [7:0] KIND_FILLED  = 8'h52;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BG     = 2'd2;

	localparam logic [8:0] WIDTH_RST  = 9'd1;
	localparam logic [8:0] HEIGHT_RST = 9'd1;
	localparam logic [7:0] BG_RST     = 8'd32;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         rect_kind;
		logic signed [23:0] rect_x;
		logic signed [23:0] rect_y;
		logic signed [23:0] rect_width;
		logic signed [23:0] rect_height;
		logic [7:0]         paint_color;
		logic [7:0]         pixel_col;
		logic [7:0]         pixel_row;
	} cmd_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       status;
	} res_t;

endpackage

`default_nettype wire

### rtl/rofr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rofr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/rofr_cover.sv
// Per-pixel coverage test of the latched rectangle against the sweep position.
`default_nettype none

module rofr_cover
	import rofr_pkg::*;
#(
	parameter int unsigned MAX_SIDE  = 256,
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          load,
	input  wire cmd_t                                          cmd,
	input  wire logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] col,
	input  wire logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] row,
	output      logic                                          paint
);

	localparam int unsigned IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned PXW = IW + FRAC_BITS + 1;
	localparam int unsigned DW  = ((PXW > 25) ? PXW : 25) + 1;
	localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

	// rectangle edges, far edges pre-added at load
	logic signed [DW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic                 filled_q;

	logic signed [DW-1:0] px, py;
	logic signed [DW-1:0] dx0, dx1, dy0, dy1;
	logic                 in_rect, near;

	always_ff @(posedge clk) begin
		if (load) begin
			x0_q     <= DW'(cmd.rect_x);
			y0_q     <= DW'(cmd.rect_y);
			x1_q     <= DW'(cmd.rect_x) + DW'(cmd.rect_width);
			y1_q     <= DW'(cmd.rect_y) + DW'(cmd.rect_height);
			filled_q <= (cmd.rect_kind == KIND_FILLED);
		end
	end

	always_comb begin
		px      = $signed({{(DW-IW){1'b0}}, col}) <<< FRAC_BITS;
		py      = $signed({{(DW-IW){1'b0}}, row}) <<< FRAC_BITS;
		dx0     = px - x0_q;
		dx1     = x1_q - px;
		dy0     = py - y0_q;
		dy1     = y1_q - py;
		in_rect = !dx0[DW-1] && !dx1[DW-1] && !dy0[DW-1] && !dy1[DW-1];
		near    = (dx0 < ONE) || (dx1 < ONE) || (dy0 < ONE) || (dy1 < ONE);
		paint   = in_rect && (filled_q || near);
	end

endmodule

`default_nettype wire

### rtl/rect_outline_fill_rasterizer_top.sv
// Top level of the rectangle rasterizer: control, sweep and result register.
//
//  channel | signals                          | direction | beat
//  cmd     | cmd_valid, cmd_stall, cmd        | in        | one clear, draw or read
//  res     | res_valid, res_stall, res        | out       | one result per command
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | one register write
//          | cfg_data                         |           |
//
// Clear and valid draw: accepted in idle, a sweep over the w*h canvas cells (one canvas
//   cell a cycle through the single RAM write port), then retired from done.
// Read: accepted in idle, then rdwait for the registered RAM read data, then done.
// Rejected draw and unused mode: accepted in idle and passed straight to done.
// Reset clears control and the size/background registers only; canvas content
//   stays undefined until a clear writes it, so there is no clearing pass.
// A finished result waits in the res register while the next command is taken;
//   the next result waits in the done state until res is free.
`default_nettype none

`include "assert_macros.svh"

module rect_outline_fill_rasterizer_top
	import rofr_pkg::*;
#(
	parameter int unsigned MAX_SIDE  = 256,
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cmd_valid,
	output      logic       cmd_stall,
	input  wire cmd_t       cmd,

	output      logic       res_valid,
	input  wire logic       res_stall,
	output      res_t       res,

	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data
);

	localparam int unsigned IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned CW    = $clog2(MAX_SIDE + 1) + 1;
	localparam int unsigned XW    = (CW > 9) ? CW : 9;
	localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SW    = 9 + CW;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SWEEP  = 2'd1;
	localparam logic [1:0] S_RDWAIT = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	// configuration registers
	logic [8:0] width_q, height_q;
	logic [7:0] bg_q;

	// control
	logic [1:0]    state_q;
	logic [IW-1:0] col_q, row_q;
	logic [AW-1:0] base_q;       // row_q * MAX_SIDE, stepped per row
	logic          clear_q;      // sweep writes background, not paint
	logic [7:0]    color_q;
	logic          rd_ok_q;      // read address inside the canvas in use
	res_t          pend_q;       // result waiting for the res register
	logic          res_valid_q;
	res_t          res_q;

	logic [CW-1:0] w_eff, h_eff;
	logic [IW-1:0] col_last, row_last;
	logic          cmd_acc, res_load;
	logic          draw_ok, rd_ok;
	logic [SW-1:0] rd_lin;
	logic          paint;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// effective canvas size: zero counts as one, clipped at MAX_SIDE
	always_comb begin
		if (width_q == 9'd0)
			w_eff = CW'(1);
		else if (XW'(width_q) > XW'(MAX_SIDE))
			w_eff = CW'(MAX_SIDE);
		else
			w_eff = CW'(width_q);
		if (height_q == 9'd0)
			h_eff = CW'(1);
		else if (XW'(height_q) > XW'(MAX_SIDE))
			h_eff = CW'(MAX_SIDE);
		else
			h_eff = CW'(height_q);
		col_last = IW'(w_eff - CW'(1));
		row_last = IW'(h_eff - CW'(1));
	end

	assign cfg_ready = 1'b1;
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	// draw is rejected on a bad kind or when neither side is positive
	assign draw_ok = ((cmd.rect_kind == KIND_OUTLINE) || (cmd.rect_kind == KIND_FILLED)) &&
		!((cmd.rect_width[23] || (cmd.rect_width == '0)) &&
		  (cmd.rect_height[23] || (cmd.rect_height == '0)));

	assign rd_ok  = (XW'(cmd.pixel_col) < XW'(w_eff)) && (XW'(cmd.pixel_row) < XW'(h_eff));
	assign rd_lin = SW'(cmd.pixel_row) * SW'(MAX_SIDE) + SW'(cmd.pixel_col);

	// RAM: sweep writes, reads addressed straight from the command beat
	assign ram_we    = (state_q == S_SWEEP) && (clear_q || paint);
	assign ram_waddr = base_q + AW'(col_q);
	assign ram_wdata = clear_q ? bg_q : color_q;
	assign ram_raddr = AW'(rd_lin);

	rofr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rofr_cover #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_cover (
		.clk   (clk),
		.load  (cmd_acc),
		.cmd   (cmd),
		.col   (col_q),
		.row   (row_q),
		.paint (paint)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			bg_q     <= BG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_BG:     bg_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// payload of the current command
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			clear_q <= (cmd.mode == MODE_CLEAR);
			color_q <= cmd.paint_color;
			rd_ok_q <= rd_ok;
		end
		if (res_load)
			res_q <= pend_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						col_q  <= '0;
						row_q  <= '0;
						base_q <= '0;
						// status is set only by a rejected draw
						pend_q <= '{pixel_value: 8'd0,
							status: (cmd.mode == MODE_DRAW) && !draw_ok};
						unique case (cmd.mode)
							MODE_CLEAR: state_q <= S_SWEEP;
							MODE_DRAW: begin
								if (draw_ok) begin
									state_q <= S_SWEEP;
								end else begin
									state_q <= S_DONE;
								end
							end
							MODE_READ: state_q <= S_RDWAIT;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_SWEEP: begin
					if (col_q == col_last) begin
						col_q  <= '0;
						row_q  <= row_q + IW'(1);
						base_q <= base_q + AW'(MAX_SIDE);
						if (row_q == row_last)
							state_q <= S_DONE;
					end else begin
						col_q <= col_q + IW'(1);
					end
				end
				S_RDWAIT: begin
					pend_q.pixel_value <= rd_ok_q ? ram_rdata : 8'd0;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (res_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RT_ASSERT(a_we_in_sweep, ram_we |-> (state_q == S_SWEEP), "canvas write outside sweep")
	`RT_ASSERT(a_sweep_bounds,
		(state_q == S_SWEEP) |-> ((col_q <= col_last) && (row_q <= row_last)),
		"sweep left the canvas in use")
	`RT_ASSERT(a_read_path,
		(cmd_acc && (cmd.mode == MODE_READ)) |=> (state_q == S_RDWAIT),
		"read did not wait for RAM data")
	`RT_ASSERT(a_done_loads,
		((state_q == S_DONE) && (!res_valid_q || !res_stall)) |=>
			(res_valid_q && (state_q == S_IDLE)),
		"finished result not moved to res")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for the rectangle rasterizer: clear, draw and read beats against a canvas predictor.
`default_nettype none

module tb_top;
	import rofr_pkg::*;

	localparam int CANVAS_SIDE = 256;
	localparam int FRAC_BITS   = 8;
	localparam int ONE         = 1 << FRAC_BITS;   // 1.0 in Q15.8
	localparam int COORD_MIN   = -8388608;
	localparam int COORD_MAX   = 8388607;

	// Codes the package leaves unnamed
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] CFG_NONE    = 2'd3;

	localparam int IDLE_PCT       = 28;
	localparam int HOLD_CYCLES    = 300;
	// Slowest beat is a full 256x256 sweep; keep a wide margin.
	localparam int WATCHDOG_LIMIT = 262144;

	// Canvas predictor plus the queue of results still owed by the block.
	class raster_scoreboard;
		logic [7:0] cells [CANVAS_SIDE * CANVAS_SIDE];
		logic [8:0] width_reg;
		logic [8:0] height_reg;
		logic [7:0] bg_reg;
		res_t       expected_q[$];
		int         fail_count;
		int         results_seen;

		function new();
			width_reg    = WIDTH_RST;
			height_reg   = HEIGHT_RST;
			bg_reg       = BG_RST;
			fail_count   = 0;
			results_seen = 0;
			foreach (cells[i]) cells[i] = 8'h00;
		endfunction

		// size in use: 0 reads as 1, anything past the array is clamped
		function int unsigned side(logic [8:0] v);
			if (v == 0) return 1;
			if (v > CANVAS_SIDE) return CANVAS_SIDE;
			return 32'(v);
		endfunction

		function void write_reg(logic [1:0] idx, logic [8:0] data);
			case (idx)
			CFG_WIDTH:  width_reg  = data;
			CFG_HEIGHT: height_reg = data;
			CFG_BG:     bg_reg     = data[7:0];
			default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void flag(string msg);
			fail_count++;
			if (fail_count <= 10) $display("[%0t] result %0d: %s", $time, results_seen, msg);
		endfunction

		function void note_cmd(cmd_t c);
			int unsigned w;
			int unsigned h;
			longint      rx, ry, rw, rh, px, py;
			bit          covered;
			bit          rim;
			res_t        r;
			w = side(width_reg);
			h = side(height_reg);
			r = '0;
			case (c.mode)
			MODE_CLEAR: begin
				for (int row = 0; row < h; row++)
					for (int col = 0; col < w; col++)
						cells[row * CANVAS_SIDE + col] = bg_reg;
			end
			MODE_DRAW: begin
				rx = longint'($signed(c.rect_x));
				ry = longint'($signed(c.rect_y));
				rw = longint'($signed(c.rect_width));
				rh = longint'($signed(c.rect_height));
				if (!(c.rect_kind == KIND_OUTLINE || c.rect_kind == KIND_FILLED) ||
				    (rw <= 0 && rh <= 0)) begin
					r.status = 1'b1;
				end else begin
					for (int row = 0; row < h; row++) begin
						py = longint'(row) * ONE;
						for (int col = 0; col < w; col++) begin
							px = longint'(col) * ONE;
							covered = !(px < rx || rx + rw < px || py < ry || ry + rh < py);
							rim = px - rx < ONE || rx + rw - px < ONE ||
							      py - ry < ONE || ry + rh - py < ONE;
							if (covered && (c.rect_kind == KIND_FILLED || rim))
								cells[row * CANVAS_SIDE + col] = c.paint_color;
						end
					end
				end
			end
			MODE_READ: begin
				if (c.pixel_col < w && c.pixel_row < h)
					r.pixel_value = cells[int'(c.pixel_row) * CANVAS_SIDE + int'(c.pixel_col)];
			end
			default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_res(res_t got);
			res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected beat pixel_value=%02h status=%0b",
				               got.pixel_value, got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.pixel_value !== want.pixel_value)
				flag($sformatf("pixel_value expected %02h actual %02h",
				               want.pixel_value, got.pixel_value));
			if (got.status !== want.status)
				flag($sformatf("status expected %0b actual %0b", want.status, got.status));
		endfunction
	endclass

	// Every block input starts at a known value.
	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_t       cmd       = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_t       res;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [8:0] cfg_data  = '0;

	bit no_idle  = 1'b0;   // both sides run flat out while set
	bit hold_req = 1'b0;   // asks the receiver for one long hold-off
	int idle_cycles = 0;

	raster_scoreboard sb;

	rect_outline_fill_rasterizer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one counted hold-off on request so that the
	// result register and the done state fill and the block stalls its input.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Result beats are sampled on the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_res(res);
	end

	// Watchdog: too long without any beat on any channel means the block hung.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cmd_t rand_cmd();
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(cmd_t)-1:0];
	endfunction

	// One command beat; random gaps before it, payload held until taken.
	task automatic send_cmd(cmd_t c);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c);
	endtask

	// Unused fields stay random so the block is seen to ignore them.
	task automatic send_op(logic [1:0] mode);
		cmd_t c;
		c = rand_cmd();
		c.mode = mode;
		send_cmd(c);
	endtask

	task automatic send_draw(logic [7:0] kind, int x, int y, int w, int h, logic [7:0] color);
		cmd_t c;
		c = rand_cmd();
		c.mode        = MODE_DRAW;
		c.rect_kind   = kind;
		c.rect_x      = x[23:0];
		c.rect_y      = y[23:0];
		c.rect_width  = w[23:0];
		c.rect_height = h[23:0];
		c.paint_color = color;
		send_cmd(c);
	endtask

	task automatic send_read(int unsigned col, int unsigned row);
		cmd_t c;
		c = rand_cmd();
		c.mode      = MODE_READ;
		c.pixel_col = col[7:0];
		c.pixel_row = row[7:0];
		send_cmd(c);
	endtask

	// Mostly rectangles around the canvas in use; one in ten keeps raw
	// 24-bit coordinates as noise.
	task automatic rand_draw(int unsigned ew, int unsigned eh);
		int   roll;
		int   x, y, w, h;
		cmd_t c;
		roll = $urandom_range(99);
		c = rand_cmd();
		c.mode = MODE_DRAW;
		if (roll < 45)      c.rect_kind = KIND_FILLED;
		else if (roll < 85) c.rect_kind = KIND_OUTLINE;
		if ($urandom_range(9) != 0) begin
			x = int'($urandom_range((ew + 2) * ONE)) - ONE;
			y = int'($urandom_range((eh + 2) * ONE)) - ONE;
			w = int'($urandom_range((ew + 1) * ONE)) - ONE / 2;
			h = int'($urandom_range((eh + 1) * ONE)) - ONE / 2;
			c.rect_x      = x[23:0];
			c.rect_y      = y[23:0];
			c.rect_width  = w[23:0];
			c.rect_height = h[23:0];
		end
		send_cmd(c);
	endtask

	// Reads land inside the canvas most of the time.
	task automatic rand_read(int unsigned ew, int unsigned eh);
		int unsigned col, row;
		col = ($urandom_range(9) < 7) ? $urandom_range(ew - 1) : $urandom_range(255);
		row = ($urandom_range(9) < 7) ? $urandom_range(eh - 1) : $urandom_range(255);
		send_read(col, row);
	endtask

	// cfg_valid stays up across back-to-back writes; the caller drops it.
	task automatic write_cfg(logic [1:0] idx, logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Only called while the block is idle. The write to the spare index must
	// leave every register alone.
	task automatic set_canvas(logic [8:0] w, logic [8:0] h, logic [8:0] bg);
		write_cfg(CFG_WIDTH, w);
		write_cfg(CFG_HEIGHT, h);
		write_cfg(CFG_BG, bg);
		write_cfg(CFG_NONE, 9'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Every beat yields a result, so an empty queue means the block is idle.
	task automatic end_phase();
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned ew, eh;
		int          roll;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 256x256 canvas: the one clear that defines every cell, then a
		// border outline over the whole area.
		set_canvas(9'd256, 9'd256, 9'($urandom));
		send_op(MODE_CLEAR);
		send_draw(KIND_OUTLINE, 0, 0, 255 * ONE, 255 * ONE, 8'hFF);
		send_read(0, 0);
		send_read(255, 255);
		end_phase();

		// Out-of-range sizes clamp to 256x1; background byte has bit 8 set.
		set_canvas(9'd511, 9'd0, 9'h1A5);
		send_op(MODE_CLEAR);
		send_draw(KIND_FILLED, 250 * ONE, -ONE / 2, COORD_MAX, ONE, 8'h5C);
		send_read(252, 0);
		end_phase();

		// Small canvas: field extremes, rejects and the one-sided cases.
		set_canvas(9'd8, 9'd6, 9'h02E);
		send_op(MODE_CLEAR);
		// covers everything; the outline finds no cell within one unit of an edge
		send_draw(KIND_FILLED, -ONE, -ONE, COORD_MAX, COORD_MAX, 8'h11);
		send_draw(KIND_OUTLINE, -ONE, -ONE, COORD_MAX, COORD_MAX, 8'h22);
		send_draw(KIND_FILLED, ONE, ONE, 3 * ONE, 2 * ONE, 8'h00);
		send_draw(KIND_OUTLINE, ONE / 2, ONE / 2, 5 * ONE, 4 * ONE, 8'hFF);
		// far left corner: right edge ends just below zero
		send_draw(KIND_FILLED, COORD_MIN, 0, COORD_MAX, ONE, 8'h44);
		// rejects: bad kinds, both sides not positive
		send_draw(8'h00, 0, 0, ONE, ONE, 8'h55);
		send_draw(8'hFF, 0, 0, ONE, ONE, 8'h55);
		send_draw(KIND_FILLED, 0, 0, 0, 0, 8'h55);
		send_draw(KIND_OUTLINE, 0, 0, COORD_MIN, COORD_MIN, 8'h55);
		// one side positive: zero height gives a single row, negative width nothing
		send_draw(KIND_FILLED, ONE, 5 * ONE, 3 * ONE, 0, 8'h33);
		send_draw(KIND_FILLED, 2 * ONE, 0, -ONE, 2 * ONE, 8'h66);
		send_read(2, 2);
		send_read(1, 5);
		send_read(8, 0);
		send_read(0, 6);
		send_op(MODE_UNUSED);
		end_phase();

		// Random phases: clear, then a mix of draws and reads with random content.
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: set_canvas(9'd1, 9'd1, 9'($urandom));
			1: set_canvas(9'd0, 9'd256, 9'($urandom));
			2: set_canvas(9'd257, 9'd2, 9'($urandom));
			default: set_canvas(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
			                    9'($urandom));
			endcase
			no_idle  = (p == 3);   // long stretch with no gaps on either side
			hold_req = (p == 5);   // receiver backs up the whole pipe
			ew = sb.side(sb.width_reg);
			eh = sb.side(sb.height_reg);
			send_op(MODE_CLEAR);
			repeat (9) begin
				roll = $urandom_range(99);
				if (roll < 30)      rand_draw(ew, eh);
				else if (roll < 90) rand_read(ew, eh);
				else if (roll < 95) send_op(MODE_CLEAR);
				else                send_op(MODE_UNUSED);
			end
			end_phase();
		end
		no_idle = 1'b0;

		// Catch any stray beat after the last expected one.
		repeat (20) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
